// ===== hdl/lspb_pkg.sv =====
package lspb_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int WIDE_BITS = 64;
	localparam int HALF_BITS = 32;
	localparam int MAG_BITS = WIDE_BITS - 1;
	localparam int CFG_INDEX_BITS = 3;
	localparam int DIV_STEPS = WORD_BITS + FRACTION_BITS;
	localparam int ROOT_STEPS = WORD_BITS - 1;
	localparam int ROOT_IN_BITS = 2 * ROOT_STEPS;
	localparam int CNT_BITS = $clog2(DIV_STEPS);
	localparam int MUL_LATENCY = 2;

	typedef logic signed [WIDE_BITS-1:0] wide_t;
	typedef logic [WORD_BITS-1:0] word_t;

	localparam wide_t WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam wide_t WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
	localparam wide_t WORD_MIN = -WORD_MAX - 64'sd1;
	localparam wide_t TOL_Q = wide_t'(((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000);
	localparam word_t END_TIME_RESET = word_t'(64'd1 << FRACTION_BITS);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_POSITION = 3'd0,
		REG_END_POSITION   = 3'd1,
		REG_BLEND_ACCEL    = 3'd2,
		REG_START_TIME     = 3'd3,
		REG_END_TIME       = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_ACCEL  = 2'd0,
		KIND_CRUISE = 2'd1,
		KIND_DECEL  = 2'd2
	} seg_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIVIDE,
		ST_DISC,
		ST_ROOT,
		ST_VB,
		ST_QB,
		ST_QBF
	} setup_state_t;

	typedef struct packed {
		logic  err;
		wide_t a;
		wide_t q0;
		wide_t vb;
		wide_t qb;
		wide_t qbf;
		wide_t t0;
		wide_t tb;
		wide_t tfb;
		wide_t tf_tol;
	} lspb_params_t;

	typedef struct packed {
		logic      err;
		seg_kind_t kind;
		wide_t     x;
		wide_t     d;
	} lspb_job_t;

	function automatic wide_t add_sat(wide_t x, wide_t y);
		wide_t s;
		s = x + y;
		if (s > WIDE_MAX)
			return WIDE_MAX;
		if (s < -WIDE_MAX)
			return -WIDE_MAX;
		return s;
	endfunction

	function automatic wide_t half_tz(wide_t v);
		wide_t r;
		r = v + (v < 0 ? 64'sd1 : 64'sd0);
		return r >>> 1;
	endfunction

	function automatic word_t to_word(wide_t v);
		wide_t c;
		c = v;
		if (c > WORD_MAX)
			c = WORD_MAX;
		if (c < WORD_MIN)
			c = WORD_MIN;
		return c[WORD_BITS-1:0];
	endfunction

endpackage

// ===== hdl/lspb_mul.sv =====
module lspb_mul (
	input  logic           clk,
	input  lspb_pkg::wide_t op_a,
	input  lspb_pkg::wide_t op_b,
	output lspb_pkg::wide_t product
);
	import lspb_pkg::*;

	localparam int FULL_BITS = 2 * MAG_BITS;

	logic [MAG_BITS-1:0] mag_a;
	logic [MAG_BITS-1:0] mag_b;
	logic [2*HALF_BITS-1:0] p_ll_s1;
	logic [2*HALF_BITS-1:0] p_lh_s1;
	logic [2*HALF_BITS-1:0] p_hl_s1;
	logic [2*HALF_BITS-1:0] p_hh_s1;
	logic neg_s1;
	logic [FULL_BITS-1:0] full;
	logic [FULL_BITS-1:0] shifted;
	wide_t mag_r;
	wide_t product_s2;

	always_comb begin
		mag_a = op_a[WIDE_BITS-1] ? MAG_BITS'(-op_a) : op_a[MAG_BITS-1:0];
		mag_b = op_b[WIDE_BITS-1] ? MAG_BITS'(-op_b) : op_b[MAG_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		p_ll_s1 <= (2*HALF_BITS)'(mag_a[HALF_BITS-1:0]) * (2*HALF_BITS)'(mag_b[HALF_BITS-1:0]);
		p_lh_s1 <= (2*HALF_BITS)'(mag_a[HALF_BITS-1:0])
			* (2*HALF_BITS)'(mag_b[MAG_BITS-1:HALF_BITS]);
		p_hl_s1 <= (2*HALF_BITS)'(mag_a[MAG_BITS-1:HALF_BITS])
			* (2*HALF_BITS)'(mag_b[HALF_BITS-1:0]);
		p_hh_s1 <= (2*HALF_BITS)'(mag_a[MAG_BITS-1:HALF_BITS])
			* (2*HALF_BITS)'(mag_b[MAG_BITS-1:HALF_BITS]);
		neg_s1 <= op_a[WIDE_BITS-1] ^ op_b[WIDE_BITS-1];
	end

	always_comb begin
		full = FULL_BITS'(p_ll_s1) + (FULL_BITS'(p_lh_s1) << HALF_BITS)
			+ (FULL_BITS'(p_hl_s1) << HALF_BITS) + (FULL_BITS'(p_hh_s1) << (2*HALF_BITS));
		shifted = full >> FRACTION_BITS;
		if (shifted > FULL_BITS'(WIDE_MAX))
			mag_r = WIDE_MAX;
		else
			mag_r = wide_t'(shifted[WIDE_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		product_s2 <= neg_s1 ? -mag_r : mag_r;
	end

	assign product = product_s2;

endmodule

// ===== hdl/lspb_setup.sv =====
module lspb_setup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lspb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  lspb_pkg::word_t                      cfg_data,
	output logic                                 setup_busy,
	output lspb_pkg::lspb_params_t               params
);
	import lspb_pkg::*;

	word_t start_position_q;
	word_t end_position_q;
	word_t blend_accel_q;
	word_t start_time_q;
	word_t end_time_q;

	setup_state_t state_q;
	setup_state_t state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic cfg_wr;

	wide_t q0_w, qf_w, a_w, t0_w, tf_w, span, diff, dq_mag, accel_mag;
	logic bad_cfg;
	logic mul_done;

	wide_t mul_a, mul_b, product;

	logic err_q;
	wide_t tt4_q;
	logic [WORD_BITS:0] div_rem_q;
	logic [DIV_STEPS-1:0] div_q;
	logic [WORD_BITS:0] div_try;
	wide_t disc_w;
	logic [ROOT_IN_BITS-1:0] root_x_q;
	logic [ROOT_STEPS-1:0] root_q;
	logic [ROOT_STEPS+2:0] root_rem_q;
	logic [ROOT_STEPS+2:0] root_try;
	logic [ROOT_STEPS+2:0] root_trial;
	wide_t dtb_w, dtb_q, vb_q, qb_q, qbf_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_position_q <= '0;
			end_position_q <= '0;
			blend_accel_q <= '0;
			start_time_q <= '0;
			end_time_q <= END_TIME_RESET;
		end else if (cfg_wr) begin
			unique case (reg_index_t'(cfg_index))
				REG_START_POSITION: start_position_q <= cfg_data;
				REG_END_POSITION:   end_position_q <= cfg_data;
				REG_BLEND_ACCEL:    blend_accel_q <= cfg_data;
				REG_START_TIME:     start_time_q <= cfg_data;
				REG_END_TIME:       end_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		q0_w = wide_t'(signed'(start_position_q));
		qf_w = wide_t'(signed'(end_position_q));
		a_w = wide_t'(signed'(blend_accel_q));
		t0_w = wide_t'({1'b0, start_time_q});
		tf_w = wide_t'({1'b0, end_time_q});
		span = tf_w - t0_w;
		diff = qf_w - q0_w;
		dq_mag = diff < 0 ? -diff : diff;
		accel_mag = a_w < 0 ? -a_w : a_w;
		bad_cfg = (span <= 0) || (a_w == 0);
		mul_done = cnt_q == CNT_BITS'(MUL_LATENCY);
		disc_w = tt4_q - wide_t'(div_q);
		dtb_w = (span >>> 1) - wide_t'(root_q);
		if (dtb_w < 0)
			dtb_w = '0;
		div_try = {div_rem_q[WORD_BITS-1:0], div_q[DIV_STEPS-1]};
		root_try = {root_rem_q[ROOT_STEPS:0], root_x_q[ROOT_IN_BITS-1:ROOT_IN_BITS-2]};
		root_trial = (ROOT_STEPS+3)'({root_q, 2'b01});
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQUARE: begin
				mul_a = span;
				mul_b = span;
			end
			ST_VB: begin
				mul_a = a_w;
				mul_b = dtb_w;
			end
			ST_QB: begin
				mul_a = vb_q;
				mul_b = dtb_q;
			end
			ST_QBF: begin
				mul_a = vb_q;
				mul_b = span - (dtb_q <<< 1);
			end
			default: ;
		endcase
	end

	lspb_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.product(product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SQUARE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q || cfg_wr) ? '0 : cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: ;
			ST_SQUARE: begin
				if (bad_cfg)
					state_d = ST_IDLE;
				else if (mul_done)
					state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1))
					state_d = ST_DISC;
			end
			ST_DISC: state_d = (disc_w < 0) ? ST_IDLE : ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == CNT_BITS'(ROOT_STEPS - 1))
					state_d = ST_VB;
			end
			ST_VB: begin
				if (mul_done)
					state_d = ST_QB;
			end
			ST_QB: begin
				if (mul_done)
					state_d = ST_QBF;
			end
			ST_QBF: begin
				if (mul_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_wr)
			state_d = ST_SQUARE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			err_q <= 1'b1;
		else if (state_q == ST_SQUARE)
			err_q <= bad_cfg;
		else if (state_q == ST_DISC && disc_w < 0)
			err_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SQUARE: begin
				div_rem_q <= '0;
				div_q <= DIV_STEPS'(dq_mag) << FRACTION_BITS;
				if (mul_done)
					tt4_q <= product >>> 2;
			end
			ST_DIVIDE: begin
				if ({1'b0, div_try} >= (WORD_BITS+2)'(accel_mag)) begin
					div_rem_q <= (WORD_BITS+1)'({1'b0, div_try} - (WORD_BITS+2)'(accel_mag));
					div_q <= {div_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					div_rem_q <= div_try;
					div_q <= {div_q[DIV_STEPS-2:0], 1'b0};
				end
			end
			ST_DISC: begin
				root_x_q <= ROOT_IN_BITS'(disc_w <<< FRACTION_BITS);
				root_q <= '0;
				root_rem_q <= '0;
			end
			ST_ROOT: begin
				root_x_q <= root_x_q << 2;
				if (root_try >= root_trial) begin
					root_rem_q <= root_try - root_trial;
					root_q <= {root_q[ROOT_STEPS-2:0], 1'b1};
				end else begin
					root_rem_q <= root_try;
					root_q <= {root_q[ROOT_STEPS-2:0], 1'b0};
				end
			end
			ST_VB: begin
				dtb_q <= dtb_w;
				if (mul_done)
					vb_q <= product;
			end
			ST_QB: begin
				if (mul_done)
					qb_q <= add_sat(q0_w, half_tz(product));
			end
			ST_QBF: begin
				if (mul_done)
					qbf_q <= add_sat(qb_q, product);
			end
			default: ;
		endcase
	end

	assign setup_busy = state_q != ST_IDLE;

	always_comb begin
		params.err = err_q;
		params.a = a_w;
		params.q0 = q0_w;
		params.vb = vb_q;
		params.qb = qb_q;
		params.qbf = qbf_q;
		params.t0 = t0_w;
		params.tb = t0_w + dtb_q;
		params.tfb = tf_w - dtb_q;
		params.tf_tol = tf_w + TOL_Q;
	end

endmodule

// ===== hdl/lspb_front.sv =====
module lspb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  lspb_pkg::word_t        sample_time,
	input  logic                   setup_busy,
	input  lspb_pkg::lspb_params_t params,
	input  logic                   take,
	output logic                   job_valid,
	output lspb_pkg::lspb_job_t    job
);
	import lspb_pkg::*;

	localparam int DEPTH = 2;

	lspb_job_t queue_q [DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic accept;
	logic pop;
	wide_t t_w;
	logic in_accel;
	logic in_decel;
	lspb_job_t new_job;

	assign busy = setup_busy || count_q == 2'(DEPTH);
	assign accept = start && !busy;
	assign job_valid = count_q != '0;
	assign pop = job_valid && take;
	assign job = queue_q[rd_ptr_q];

	always_comb begin
		t_w = wide_t'({1'b0, sample_time});
		in_accel = t_w >= params.t0 && t_w <= params.tb;
		in_decel = t_w >= params.tfb && t_w <= params.tf_tol;
		new_job.err = params.err;
		if (in_accel) begin
			new_job.kind = KIND_ACCEL;
			new_job.x = params.a;
			new_job.d = t_w - params.t0;
		end else if (in_decel) begin
			new_job.kind = KIND_DECEL;
			new_job.x = -params.a;
			new_job.d = t_w - params.tfb;
		end else begin
			new_job.kind = KIND_CRUISE;
			new_job.x = params.vb;
			new_job.d = t_w - params.tb;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			queue_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(accept) - 2'(pop);
		end
	end

endmodule

// ===== hdl/lspb_back.sv =====
module lspb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  lspb_pkg::lspb_job_t    job,
	input  lspb_pkg::lspb_params_t params,
	output logic                   take,
	output logic                   done,
	output lspb_pkg::word_t        position,
	output lspb_pkg::word_t        velocity,
	output lspb_pkg::word_t        acceleration,
	output logic [1:0]             segment_kind,
	output logic                   accel_too_small
);
	import lspb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic err_s1, err_s2, err_s3, err_s4;
	seg_kind_t kind_s1, kind_s2, kind_s3, kind_s4;
	wide_t d_s1, d_s2;
	wide_t m1, m2, m3;
	wide_t vel_w;
	wide_t vel_s3, vel_s4;
	wide_t m1_s3, m1_s4, m2_s3, m2_s4;
	wide_t pos_w, acc_w;

	logic done_q;
	word_t position_q, velocity_q, acceleration_q;
	logic [1:0] kind_q;
	logic too_small_q;

	assign take = job_valid;

	lspb_mul u_mul_rate (
		.clk    (clk),
		.op_a   (job.x),
		.op_b   (job.d),
		.product(m1)
	);

	lspb_mul u_mul_cruise (
		.clk    (clk),
		.op_a   (params.vb),
		.op_b   (job.d),
		.product(m2)
	);

	lspb_mul u_mul_square (
		.clk    (clk),
		.op_a   (m1),
		.op_b   (d_s2),
		.product(m3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= job_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q <= valid_s4;
		end
	end

	always_comb begin
		case (kind_s2)
			KIND_ACCEL: vel_w = m1;
			KIND_DECEL: vel_w = add_sat(params.vb, m1);
			default:    vel_w = params.vb;
		endcase
	end

	always_ff @(posedge clk) begin
		err_s1 <= job.err;
		kind_s1 <= job.kind;
		d_s1 <= job.d;
		err_s2 <= err_s1;
		kind_s2 <= kind_s1;
		d_s2 <= d_s1;
		err_s3 <= err_s2;
		kind_s3 <= kind_s2;
		vel_s3 <= vel_w;
		m1_s3 <= m1;
		m2_s3 <= m2;
		err_s4 <= err_s3;
		kind_s4 <= kind_s3;
		vel_s4 <= vel_s3;
		m1_s4 <= m1_s3;
		m2_s4 <= m2_s3;
	end

	always_comb begin
		case (kind_s4)
			KIND_ACCEL: begin
				pos_w = add_sat(params.q0, half_tz(m3));
				acc_w = params.a;
			end
			KIND_DECEL: begin
				pos_w = add_sat(add_sat(params.qbf, m2_s4), half_tz(m3));
				acc_w = -params.a;
			end
			default: begin
				pos_w = add_sat(params.qb, m1_s4);
				acc_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (err_s4) begin
			position_q <= '0;
			velocity_q <= '0;
			acceleration_q <= '0;
			kind_q <= KIND_ACCEL;
			too_small_q <= 1'b1;
		end else begin
			position_q <= to_word(pos_w);
			velocity_q <= to_word(vel_s4);
			acceleration_q <= to_word(acc_w);
			kind_q <= kind_s4;
			too_small_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign position = position_q;
	assign velocity = velocity_q;
	assign acceleration = acceleration_q;
	assign segment_kind = kind_q;
	assign accel_too_small = too_small_q;

endmodule

// ===== hdl/lspb_trajectory_eval.sv =====
// A sample accepted into the front-end queue passes through back-end stages s1 to s4 and the output register to done.
// Throughput: one sample per cycle while busy is low; the receiver cannot stall and done is never held off.
// Blend parameters are recomputed after reset and after every configuration write:
// busy stays high while setup runs, including the 48-step divider and 31-step square root.
// Reset is asynchronous and active low; it resets all control state.
module lspb_trajectory_eval (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  lspb_pkg::word_t                      sample_time,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lspb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  lspb_pkg::word_t                      cfg_data,
	output logic                                 done,
	output lspb_pkg::word_t                      position,
	output lspb_pkg::word_t                      velocity,
	output lspb_pkg::word_t                      acceleration,
	output logic [1:0]                           segment_kind,
	output logic                                 accel_too_small
);
	import lspb_pkg::*;

	lspb_params_t params;
	lspb_job_t job;
	logic setup_busy;
	logic job_valid;
	logic take;

	lspb_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.setup_busy(setup_busy),
		.params    (params)
	);

	lspb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample_time(sample_time),
		.setup_busy (setup_busy),
		.params     (params),
		.take       (take),
		.job_valid  (job_valid),
		.job        (job)
	);

	lspb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job            (job),
		.params         (params),
		.take           (take),
		.done           (done),
		.position       (position),
		.velocity       (velocity),
		.acceleration   (acceleration),
		.segment_kind   (segment_kind),
		.accel_too_small(accel_too_small)
	);

endmodule

// ===== hdl/lspb_checker.sv =====
module lspb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] sample_time,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        done,
	input logic [31:0] position,
	input logic [31:0] velocity,
	input logic [31:0] acceleration,
	input logic [1:0]  segment_kind,
	input logic        accel_too_small
);
	import lspb_pkg::*;

	// Every accepted transaction yields exactly one result on done.
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 6))
		else $error("result strobe does not match an accepted transaction");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && accel_too_small |-> position == 32'd0 && velocity == 32'd0
			&& acceleration == 32'd0 && segment_kind == KIND_ACCEL)
		else $error("error result carries nonzero fields");

	a_cruise_no_accel: assert property (@(posedge clk) disable iff (!arst_n)
		done && segment_kind == KIND_CRUISE |-> acceleration == 32'd0)
		else $error("cruise segment reports acceleration");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> segment_kind == KIND_ACCEL || segment_kind == KIND_CRUISE
			|| segment_kind == KIND_DECEL)
		else $error("undefined segment kind");

	a_cfg_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("configuration write did not start a parameter update");

endmodule

bind lspb_trajectory_eval lspb_checker u_lspb_checker (.*);
